>>> hdl/mfdf_pkg.sv
// Package for the mesh flood duplicate filter.
// Holds payload structs, codes, sizes, controller types and the cache slot wrap helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfdf_pkg;

    // Sizes of the key cache and the frame limits
    localparam int SEEN_DEPTH = 64;
    localparam int SEEN_AW    = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int SEEN_CW    = $clog2(SEEN_DEPTH + 1);

    localparam logic [9:0] HEADER_BYTES    = 10'd16;
    localparam logic [9:0] MAX_FRAME_BYTES = 10'd256;
    localparam logic [9:0] MAX_DATA_BYTES  = 10'd237;

    localparam logic [SEEN_CW-1:0] SEEN_FULL = SEEN_CW'(SEEN_DEPTH);

    // Command field codes
    localparam logic CMD_RECEIVE  = 1'b0;
    localparam logic CMD_TRANSMIT = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_NODE_ID      = 3'd0;
    localparam logic [2:0] CFG_CHAN_HASH    = 3'd1;
    localparam logic [2:0] CFG_HOP_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_RELAY_ENABLE = 3'd3;
    localparam logic [2:0] CFG_ID_SEED      = 3'd4;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED    = 3'd0,
        ST_BAD_SIZE    = 3'd1,
        ST_OWN         = 3'd2,
        ST_OTHER_CHAN  = 3'd3,
        ST_DUPLICATE   = 3'd4,
        ST_UNDECODABLE = 3'd5,
        ST_TOO_LARGE   = 3'd6,
        ST_SENT        = 3'd7
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [31:0] source_node;
        logic [31:0] dest_node;
        logic [31:0] packet_num;
        logic [7:0]  frame_channel;
        logic [2:0]  frame_hop_limit;
        logic [2:0]  frame_hop_start;
        logic [9:0]  length;
        logic        decode_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] assigned_id;
        logic [2:0]  hop_count;
        logic        relay;
        logic [2:0]  relay_hop_limit;
        logic [7:0]  relay_byte;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_CMP,
        S_INSERT,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic decide;
        logic rd_issue;
        logic compare;
        logic insert;
        logic load_out;
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic drop;
        logic cache_empty;
        logic match;
        logic last;
        logic out_free;
    } t_dp_stat;

    // Slot index of base plus offset, wrapped at the cache depth (sum below twice the depth)
    function automatic logic [SEEN_AW-1:0] wrap_add(input logic [SEEN_AW-1:0] base,
                                                    input logic [SEEN_CW-1:0] off);
        logic [SEEN_CW:0] sum;
        sum = {{(SEEN_CW + 1 - SEEN_AW){1'b0}}, base} + {1'b0, off};
        if (sum >= (SEEN_CW + 1)'(SEEN_DEPTH)) begin
            sum = sum - (SEEN_CW + 1)'(SEEN_DEPTH);
        end
        return sum[SEEN_AW-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/mfdf_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mfdf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/mfdf_ctrl.sv
// Controller of the duplicate filter: sequences decide, cache scan, insert and result load.
// Depends on mfdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mfdf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire mfdf_pkg::t_dp_stat i_stat,
    output      mfdf_pkg::t_ctrl_cmd o_cmd,
    output      logic               o_in_stall
);

    mfdf_pkg::t_state r_state;
    mfdf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfdf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            mfdf_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = mfdf_pkg::S_DECIDE;
                end
            end
            mfdf_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                priority if (i_stat.drop) begin
                    n_state = mfdf_pkg::S_DONE;
                end else if (i_stat.cache_empty) begin
                    n_state = mfdf_pkg::S_INSERT;
                end else begin
                    n_state = mfdf_pkg::S_READ;
                end
            end
            mfdf_pkg::S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = mfdf_pkg::S_CMP;
            end
            mfdf_pkg::S_CMP: begin
                o_cmd.compare = 1'b1;
                priority if (i_stat.match) begin
                    n_state = mfdf_pkg::S_DONE;
                end else if (i_stat.last) begin
                    n_state = mfdf_pkg::S_INSERT;
                end else begin
                    n_state = mfdf_pkg::S_READ;
                end
            end
            mfdf_pkg::S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = mfdf_pkg::S_DONE;
            end
            mfdf_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mfdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mfdf_pkg::S_IDLE;
            end
        endcase
    end

    // A found key ends the scan; an accepted beat holds the input off while it is worked
    a_match_leaves_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfdf_pkg::S_CMP && i_stat.match) |=> (r_state == mfdf_pkg::S_DONE))
        else $error("scan did not stop on a matching key");
    a_insert_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfdf_pkg::S_INSERT) |=> (r_state == mfdf_pkg::S_DONE))
        else $error("insert not followed by result");
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_in |=> o_in_stall)
        else $error("input not stalled while an item is in work");

endmodule

`default_nettype wire

>>> hdl/mfdf_dp.sv
// Datapath of the duplicate filter: config registers, item register, key cache,
// packet id counter and result register. Depends on mfdf_pkg and mfdf_ram.
`timescale 1ns / 1ps
`default_nettype none

module mfdf_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    input  wire mfdf_pkg::t_in_item   i_in_data,
    input  wire logic                 i_out_stall,
    input  wire mfdf_pkg::t_ctrl_cmd  i_cmd,
    output      mfdf_pkg::t_dp_stat   o_stat,
    output      logic                 o_out_valid,
    output      mfdf_pkg::t_out_item  o_out_data
);

    // Configuration registers
    logic [31:0] r_node_id;
    logic [7:0]  r_chan_hash;
    logic [2:0]  r_hop_limit;
    logic        r_relay_en;
    logic [31:0] r_id_seed;

    // Item and work registers
    mfdf_pkg::t_in_item r_in;
    mfdf_pkg::t_status  r_status;
    logic [63:0]        r_key;
    logic [mfdf_pkg::SEEN_CW-1:0] r_idx;
    logic [mfdf_pkg::SEEN_CW-1:0] r_count;
    logic [mfdf_pkg::SEEN_AW-1:0] r_oldest;
    logic [31:0]        r_id_ctr;
    logic               r_out_valid;
    mfdf_pkg::t_out_item r_out;

    logic               drop;
    mfdf_pkg::t_status  drop_code;
    logic [31:0]        new_id;
    logic [31:0]        id_inc;
    logic [63:0]        ram_q;
    logic [mfdf_pkg::SEEN_AW-1:0] rd_addr;
    logic [mfdf_pkg::SEEN_AW-1:0] wr_addr;
    logic [mfdf_pkg::SEEN_CW:0]   idx_next;
    logic               accepted;
    logic               out_free;
    mfdf_pkg::t_out_item n_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id   <= '0;
            r_chan_hash <= '0;
            r_hop_limit <= 3'd3;
            r_relay_en  <= 1'b0;
            r_id_seed   <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mfdf_pkg::CFG_NODE_ID:      r_node_id   <= i_cfg_data;
                mfdf_pkg::CFG_CHAN_HASH:    r_chan_hash <= i_cfg_data[7:0];
                mfdf_pkg::CFG_HOP_LIMIT:    r_hop_limit <= i_cfg_data[2:0];
                mfdf_pkg::CFG_RELAY_ENABLE: r_relay_en  <= i_cfg_data[0];
                mfdf_pkg::CFG_ID_SEED:      r_id_seed   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Early drop checks, in priority order
    always_comb begin
        drop      = 1'b1;
        drop_code = mfdf_pkg::ST_BAD_SIZE;
        priority if (r_in.cmd == mfdf_pkg::CMD_TRANSMIT) begin
            drop      = (r_in.length > mfdf_pkg::MAX_DATA_BYTES);
            drop_code = mfdf_pkg::ST_TOO_LARGE;
        end else if (r_in.length < mfdf_pkg::HEADER_BYTES
                     || r_in.length > mfdf_pkg::MAX_FRAME_BYTES) begin
            drop_code = mfdf_pkg::ST_BAD_SIZE;
        end else if (r_in.source_node == r_node_id) begin
            drop_code = mfdf_pkg::ST_OWN;
        end else if (r_in.frame_channel != r_chan_hash) begin
            drop_code = mfdf_pkg::ST_OTHER_CHAN;
        end else begin
            drop = 1'b0;
        end
    end

    // Packet id: seeded on first use, skips zero on wrap
    assign new_id = (r_id_ctr == 32'd0) ? (r_id_seed | 32'd1) : r_id_ctr;
    assign id_inc = new_id + 32'd1;

    // Item register and work state
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.decide) begin
            r_idx <= '0;
            if (drop) begin
                r_status <= drop_code;
            end else if (r_in.cmd == mfdf_pkg::CMD_TRANSMIT) begin
                r_status <= mfdf_pkg::ST_SENT;
            end else if (r_in.decode_ok) begin
                r_status <= mfdf_pkg::ST_ACCEPTED;
            end else begin
                r_status <= mfdf_pkg::ST_UNDECODABLE;
            end
            if (r_in.cmd == mfdf_pkg::CMD_TRANSMIT) begin
                r_key <= {r_node_id, new_id};
            end else begin
                r_key <= {r_in.source_node, r_in.packet_num};
            end
        end
        if (i_cmd.compare) begin
            if (o_stat.match) begin
                if (r_in.cmd == mfdf_pkg::CMD_RECEIVE) begin
                    r_status <= mfdf_pkg::ST_DUPLICATE;
                end
            end else begin
                r_idx <= idx_next[mfdf_pkg::SEEN_CW-1:0];
            end
        end
    end

    // Id counter, cache fill count and oldest slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_ctr <= '0;
            r_count  <= '0;
            r_oldest <= '0;
        end else begin
            if (i_cmd.decide && !drop && r_in.cmd == mfdf_pkg::CMD_TRANSMIT) begin
                r_id_ctr <= (id_inc == 32'd0) ? 32'd1 : id_inc;
            end
            if (i_cmd.insert) begin
                if (r_count < mfdf_pkg::SEEN_FULL) begin
                    r_count <= r_count + mfdf_pkg::SEEN_CW'(1);
                end else begin
                    r_oldest <= mfdf_pkg::wrap_add(r_oldest, mfdf_pkg::SEEN_CW'(1));
                end
            end
        end
    end

    // Key cache: scan from the oldest slot, append after the newest
    assign rd_addr  = mfdf_pkg::wrap_add(r_oldest, r_idx);
    assign wr_addr  = mfdf_pkg::wrap_add(r_oldest, r_count);
    assign idx_next = {1'b0, r_idx} + (mfdf_pkg::SEEN_CW + 1)'(1);

    mfdf_ram #(
        .WIDTH (64),
        .DEPTH (mfdf_pkg::SEEN_DEPTH)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert),
        .i_waddr (wr_addr),
        .i_wdata (r_key),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Result fields
    assign accepted = (r_status == mfdf_pkg::ST_ACCEPTED);
    always_comb begin
        n_out        = '0;
        n_out.status = r_status;
        if (r_status == mfdf_pkg::ST_SENT) begin
            n_out.assigned_id = r_key[31:0];
        end
        if (accepted) begin
            if (r_in.frame_hop_start >= r_in.frame_hop_limit) begin
                n_out.hop_count = r_in.frame_hop_start - r_in.frame_hop_limit;
            end
            if (r_relay_en && r_in.dest_node != r_node_id
                && r_in.frame_hop_limit != 3'd0 && r_in.packet_num != 32'd0) begin
                n_out.relay           = 1'b1;
                n_out.relay_hop_limit = r_in.frame_hop_limit - 3'd1;
                n_out.relay_byte      = r_node_id[7:0];
            end
        end
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    // Status to the controller
    assign o_stat.drop        = drop;
    assign o_stat.cache_empty = (r_count == '0);
    assign o_stat.match       = (ram_q == r_key);
    assign o_stat.last        = (idx_next == {1'b0, r_count});
    assign o_stat.out_free    = out_free;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mfdf_pkg::SEEN_FULL)
        else $error("cache fill count beyond depth");
    a_oldest_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oldest != '0) |-> (r_count == mfdf_pkg::SEEN_FULL))
        else $error("oldest slot moved before the cache filled");
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && !drop && r_in.cmd == mfdf_pkg::CMD_TRANSMIT) |=> (r_id_ctr != 32'd0))
        else $error("packet id counter fell to zero after a send");
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

>>> hdl/mesh_flood_duplicate_filter_unit.sv
// Mesh flood duplicate filter: items in, one result beat out per item, config write port.
// Clock and reset come straight through; ports carry valid/stall handshakes.
// The input channel takes one beat (received frame header or local transmit request) when
// i_in_valid is high and o_in_stall low. Each item yields exactly one result beat on the
// output channel, taken when o_out_valid is high and i_out_stall low.
// Flow: a beat dropped for size, own source, channel or too large length goes from the decide
// step straight to its result. An item that reaches the key cache scans the live keys, oldest
// first, each by a RAM read then a compare, up to 64 keys, and stops on a matching key.
// One item is in work at a time.
// The result sits in an output register; while it waits, the next item is accepted and
// worked, then held back until the waiting beat is taken. A stalled result stays unchanged.
// Config: i_cfg_valid/o_cfg_ready, register index, data; user writes only while the block is
// idle (not enforced by the block); o_cfg_ready is always high, unknown indexes are ignored.
// Reset (synchronous, active low) empties the key cache, unseeds the id counter and loads
// the register defaults; the cache memory itself needs no clearing pass.
// Depends on mfdf_pkg, mfdf_ctrl, mfdf_dp and mfdf_ram.
`timescale 1ns / 1ps
`default_nettype none

module mesh_flood_duplicate_filter_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output      logic                o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data,
    input  wire logic                i_in_valid,
    output      logic                o_in_stall,
    input  wire mfdf_pkg::t_in_item  i_in_data,
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      mfdf_pkg::t_out_item o_out_data
);

    mfdf_pkg::t_ctrl_cmd cmd;
    mfdf_pkg::t_dp_stat  stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    mfdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Registers, cache and result
    mfdf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
